// File: rtl/core/bsp_pkg.sv
package bsp_pkg;

    // bitmap geometry
    localparam int MAX_BITS   = 1024;
    localparam int WORD_BITS  = 32;
    localparam int NUM_WORDS  = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);

    // field widths
    localparam int POS_W = 10;
    localparam int CNT_W = $clog2(MAX_BITS) + 1;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_LENGTH = '0;

    // item operations
    typedef enum logic [1:0] {
        FUNC_READ   = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_FILL   = 2'd2,
        FUNC_INVERT = 2'd3
    } t_func;

    typedef struct packed {
        t_func            func;
        logic [POS_W-1:0] bit_position;
        logic             write_value;
    } t_in_item;

    typedef struct packed {
        logic             bit_value;
        logic [CNT_W-1:0] ones_count;
        logic             any_set;
        logic             out_of_range;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic commit;
    } t_cmd;

endpackage

// File: rtl/core/bsp_ram.sv
module bsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/bsp_ctrl.sv
module bsp_ctrl
    import bsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // handshake decode
    assign out_free     = !r_out_valid || !i_out_stall;
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cmd.accept = i_in_valid && (r_state == S_IDLE);
    assign o_cmd.commit = (r_state == S_EXEC) && out_free;

    // next state and output valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (o_cmd.commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/bsp_dpath.sv
module bsp_dpath
    import bsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  t_in_item          i_in_data,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata
);

    // held request and running state
    t_in_item               r_req;
    t_out_item              r_out;
    t_out_item              n_out;
    logic [NUM_WORDS-1:0]   r_valid;
    logic [NUM_WORDS-1:0]   n_valid;
    logic                   r_dflt;
    logic                   n_dflt;
    logic                   r_inv;
    logic                   n_inv;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [CNT_W-1:0]       r_length;
    logic [CNT_W-1:0]       cfg_length;
    logic                   cfg_wr;

    logic [WORD_IDX_W-1:0]  wi;
    logic [BIT_IDX_W-1:0]   bi;
    logic [WORD_BITS-1:0]   ram_rdata;
    logic [WORD_BITS-1:0]   word_act;
    logic [WORD_BITS-1:0]   new_word;
    logic                   ram_we;
    logic                   in_range;
    logic                   old_bit;
    logic                   res_bit;

    // length register write, low CNT_W bits of pwdata saturated to the bitmap size
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_LENGTH);
    always_comb begin
        if (pwdata[CNT_W-1:0] > CNT_W'(MAX_BITS)) begin
            cfg_length = CNT_W'(MAX_BITS);
        end else begin
            cfg_length = pwdata[CNT_W-1:0];
        end
    end
    assign prdata = {{(APB_DW-CNT_W){1'b0}}, r_length};

    // word store
    bsp_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (wi),
        .i_wr_data (new_word ^ {WORD_BITS{r_inv}}),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (i_in_data.bit_position[BIT_IDX_W +: WORD_IDX_W]),
        .o_rd_data (ram_rdata)
    );

    // decode of the held request
    assign wi       = r_req.bit_position[BIT_IDX_W +: WORD_IDX_W];
    assign bi       = r_req.bit_position[BIT_IDX_W-1:0];
    assign in_range = {{(CNT_W-POS_W){1'b0}}, r_req.bit_position} < r_length;

    // stored word seen through fill default and invert flag
    assign word_act = (r_valid[wi] ? ram_rdata : {WORD_BITS{r_dflt}}) ^ {WORD_BITS{r_inv}};
    assign old_bit  = word_act[bi];

    always_comb begin
        new_word     = word_act;
        new_word[bi] = r_req.write_value;
    end

    // operation
    always_comb begin
        n_valid = r_valid;
        n_dflt  = r_dflt;
        n_inv   = r_inv;
        n_count = r_count;
        ram_we  = 1'b0;
        res_bit = old_bit;
        case (r_req.func)
            FUNC_WRITE: begin
                res_bit = r_req.write_value;
                if (in_range && i_cmd.commit) begin
                    ram_we      = 1'b1;
                    n_valid[wi] = 1'b1;
                end
                if (in_range && r_req.write_value && !old_bit) begin
                    n_count = r_count + CNT_W'(1);
                end else if (in_range && !r_req.write_value && old_bit) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            FUNC_FILL: begin
                res_bit = r_req.write_value;
                n_valid = '0;
                n_dflt  = r_req.write_value;
                n_inv   = 1'b0;
                n_count = r_req.write_value ? r_length : '0;
            end
            FUNC_INVERT: begin
                res_bit = !old_bit;
                n_inv   = !r_inv;
                n_count = r_length - r_count;
            end
            default: begin
                res_bit = old_bit;
            end
        endcase
    end

    // result fields
    always_comb begin
        n_out.bit_value    = in_range && res_bit;
        n_out.ones_count   = n_count;
        n_out.any_set      = (n_count != '0);
        n_out.out_of_range = !in_range;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_dflt   <= 1'b0;
            r_inv    <= 1'b0;
            r_count  <= '0;
            r_length <= CNT_W'(MAX_BITS);
        end else if (cfg_wr) begin
            r_valid  <= '0;
            r_dflt   <= 1'b0;
            r_inv    <= 1'b0;
            r_count  <= '0;
            r_length <= cfg_length;
        end else if (i_cmd.commit) begin
            r_valid  <= n_valid;
            r_dflt   <= n_dflt;
            r_inv    <= n_inv;
            r_count  <= n_count;
        end
    end

    // request and result holding registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_in_data;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

// File: rtl/core/bitmap_store_with_popcount.sv
// Bitmap store of up to MAX_BITS positions with a running count of ones.
// Request channel: i_in_valid / o_in_stall carry i_in_data (func, bit_position,
// write_value); a request is taken at an edge with valid high and stall low.
// Result channel: o_out_valid / i_out_stall carry o_out_data, one result per
// request, in request order.
// A new request is not taken before the previous one is done: the word is
// read from the word RAM at the accept edge and, for a write, written back at
// the commit edge, where the result is registered and o_out_valid rises; a
// stalled, still-held result delays the commit. Fill and invert act through a
// per-word valid bit, a fill value and an invert flag, not the RAM words.
// The input stalls while a request is in flight; a new request is taken
// while the previous result is still held. When the receiver stalls, the
// finished request waits in the datapath until the result register frees.
// bitmap_length sits at APB byte address 0; pready is always high.
// Reset (synchronous, active low) and any write of bitmap_length clear the
// store and the count at once: no clearing pass. Reset length is MAX_BITS.
module bitmap_store_with_popcount
    import bsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cmd cmd;

    assign pready = 1'b1;

    // sequencing
    bsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // store, count and registers
    bsp_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata)
    );

    // a taken request blocks the input for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after request");

    // any-set flag agrees with the count
    a_any_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.any_set == (o_out_data.ones_count != '0)))
        else $error("any_set disagrees with ones_count");

    // out-of-range results carry a zero bit
    a_oor_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.out_of_range |-> !o_out_data.bit_value)
        else $error("bit set on out-of-range result");

    // count never exceeds the bitmap size
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.ones_count <= CNT_W'(MAX_BITS)))
        else $error("ones_count above bitmap size");

endmodule

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bsp_pkg::*;

    localparam int POS_MAX     = (1 << POS_W) - 1;
    localparam int IDLE_PCT    = 24;
    localparam int REPORT_MAX  = 10;
    localparam int END_SLACK   = 20;

    // dut connections, every input known from time zero
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in_item          i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out_data;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // shadow of the bitmap and its length
    logic [MAX_BITS-1:0] bitmap_bits = '0;
    int unsigned         bitmap_len  = MAX_BITS;

    t_in_item  pending_requests[$];
    t_out_item expected_results[$];

    bit no_idle      = 1'b0;
    bit req_accepted = 1'b0;

    int unsigned mismatch_count  = 0;
    int unsigned results_checked = 0;
    int unsigned requests_taken  = 0;
    int unsigned sweeps_taken    = 0;
    int unsigned range_misses    = 0;
    int unsigned length_settings = 0;

    bitmap_store_with_popcount DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // apply one request to the shadow bitmap and return the result it yields
    function automatic t_out_item apply_request(t_in_item req);
        t_out_item   res;
        int unsigned ones;
        logic        hit;
        hit = req.bit_position < bitmap_len;
        case (req.func)
            FUNC_WRITE: begin
                if (hit) bitmap_bits[req.bit_position] = req.write_value;
            end
            FUNC_FILL: begin
                bitmap_bits = {MAX_BITS{req.write_value}};
            end
            FUNC_INVERT: begin
                bitmap_bits = ~bitmap_bits;
            end
            default: begin
            end
        endcase
        ones = 0;
        for (int i = 0; i < bitmap_len; i++) ones += bitmap_bits[i];
        res.bit_value    = hit ? bitmap_bits[req.bit_position] : 1'b0;
        res.ones_count   = CNT_W'(ones);
        res.any_set      = (ones != 0);
        res.out_of_range = !hit;
        return res;
    endfunction

    function automatic t_in_item make_request(t_func f, int unsigned pos, logic v);
        t_in_item req;
        req.func         = f;
        req.bit_position = POS_W'(pos);
        req.write_value  = v;
        return req;
    endfunction

    // append a request to the driver's queue
    function automatic void queue_request(t_in_item req);
        pending_requests.insert(pending_requests.size(), req);
    endfunction

    // random request, biased toward the current length boundary
    function automatic t_in_item random_request();
        t_in_item    req;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) req.func = FUNC_READ;
        else if (pick < 80) req.func = FUNC_WRITE;
        else if (pick < 90) req.func = FUNC_FILL;
        else req.func = FUNC_INVERT;
        req.write_value = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (bitmap_len == 0 || pick < 20) begin
            req.bit_position = POS_W'($urandom_range(0, POS_MAX));
        end else if (pick < 30) begin
            req.bit_position = POS_W'(bitmap_len - 1);
        end else if (pick < 40) begin
            req.bit_position = POS_W'((bitmap_len > POS_MAX) ? POS_MAX : bitmap_len);
        end else begin
            req.bit_position = POS_W'($urandom_range(0, bitmap_len - 1));
        end
        return req;
    endfunction

    // wait until every queued request has gone through and been checked
    task automatic drain();
        while (pending_requests.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    // apb write of the length register, called at a falling edge while idle
    task automatic set_length(int unsigned len_value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_LENGTH, 2'b00};
        pwdata  <= APB_DW'(len_value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        bitmap_len  = (len_value > MAX_BITS) ? MAX_BITS : len_value;
        bitmap_bits = '0;
        length_settings++;
    endtask

    task automatic run_random_phase(int unsigned len_value, int unsigned count);
        set_length(len_value);
        repeat (count) queue_request(random_request());
        drain();
    endtask

    // request driver: new request or idle, and a random output stall, on the falling edge
    always @(negedge i_clk) begin
        i_out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
        if (req_accepted || !i_in_valid) begin
            req_accepted = 1'b0;
            if (pending_requests.size() != 0 &&
                (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_requests.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: predict on request accept, check on result accept
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                want = apply_request(i_in_data);
                expected_results.insert(expected_results.size(), want);
                req_accepted = 1'b1;
                requests_taken++;
                if (i_in_data.func == FUNC_FILL || i_in_data.func == FUNC_INVERT)
                    sweeps_taken++;
                if (want.out_of_range) range_misses++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: unexpected result bit=%0d count=%0d any=%0d oor=%0d",
                                 $realtime, o_out_data.bit_value, o_out_data.ones_count,
                                 o_out_data.any_set, o_out_data.out_of_range);
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (o_out_data.bit_value    !== want.bit_value  ||
                        o_out_data.ones_count   !== want.ones_count ||
                        o_out_data.any_set      !== want.any_set    ||
                        o_out_data.out_of_range !== want.out_of_range) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display({"%0t: result mismatch exp bit=%0d count=%0d any=%0d ",
                                      "oor=%0d got bit=%0d count=%0d any=%0d oor=%0d"},
                                     $realtime, want.bit_value, want.ones_count,
                                     want.any_set, want.out_of_range,
                                     o_out_data.bit_value, o_out_data.ones_count,
                                     o_out_data.any_set, o_out_data.out_of_range);
                    end
                end
            end
        end
    end

    // stimulus sequence
    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // full length after reset: extremes, every operation
        queue_request(make_request(FUNC_READ,   0,       1'b0));
        queue_request(make_request(FUNC_READ,   POS_MAX, 1'b1));
        queue_request(make_request(FUNC_WRITE,  0,       1'b1));
        queue_request(make_request(FUNC_WRITE,  POS_MAX, 1'b1));
        queue_request(make_request(FUNC_READ,   POS_MAX, 1'b0));
        queue_request(make_request(FUNC_WRITE,  POS_MAX, 1'b0));
        queue_request(make_request(FUNC_FILL,   512,     1'b1));
        queue_request(make_request(FUNC_INVERT, 0,       1'b0));
        queue_request(make_request(FUNC_WRITE,  511,     1'b1));
        queue_request(make_request(FUNC_INVERT, 511,     1'b1));
        queue_request(make_request(FUNC_FILL,   POS_MAX, 1'b0));
        drain();

        // short length: positions at and past the end, sweeps with a stray position
        set_length(33);
        queue_request(make_request(FUNC_WRITE,  33,      1'b1));
        queue_request(make_request(FUNC_WRITE,  32,      1'b1));
        queue_request(make_request(FUNC_READ,   POS_MAX, 1'b1));
        queue_request(make_request(FUNC_FILL,   40,      1'b1));
        queue_request(make_request(FUNC_INVERT, 32,      1'b0));
        drain();

        // zero length: everything out of range, count stays zero
        set_length(0);
        queue_request(make_request(FUNC_READ,   0,       1'b0));
        queue_request(make_request(FUNC_FILL,   0,       1'b1));
        queue_request(make_request(FUNC_WRITE,  0,       1'b1));
        drain();

        // length above the maximum saturates
        set_length(2047);
        queue_request(make_request(FUNC_FILL,   POS_MAX, 1'b1));
        queue_request(make_request(FUNC_WRITE,  POS_MAX, 1'b0));
        drain();

        // random phases over a spread of lengths
        run_random_phase(MAX_BITS, 100);
        run_random_phase(1, 40);
        run_random_phase(31, 80);
        run_random_phase(32, 80);
        run_random_phase($urandom_range(0, 2047), 90);
        run_random_phase(1500, 90);
        run_random_phase(0, 20);
        run_random_phase(33, 80);

        // long stretch without idling on either side
        no_idle = 1'b1;
        run_random_phase(MAX_BITS, 170);
        no_idle = 1'b0;

        repeat (END_SLACK) @(posedge i_clk);

        $display("ran %0d requests over %0d length settings: %0d fills or inverts, %0d out of range",
                 requests_taken, length_settings, sweeps_taken, range_misses);
        $display("compared %0d results, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_400_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: bitmap_store_with_popcount.f
rtl/core/bsp_pkg.sv
rtl/core/bsp_ram.sv
rtl/core/bsp_ctrl.sv
rtl/core/bsp_dpath.sv
rtl/core/bitmap_store_with_popcount.sv
tb/testbench.sv
